>>> rtl/bmru_pkg.sv
// ----------------------------------------------------------------------------
// bmru_pkg
// Types and constants for the allocation bitmap range update core.
// ----------------------------------------------------------------------------
package bmru_pkg;

    localparam int DEF_BITMAP_WORDS = 1024;
    localparam int DEF_WORD_BITS    = 64;

    localparam int CFG_BYTES_W = 14;
    localparam logic [CFG_BYTES_W-1:0] RESET_BYTES = 14'd8192;

    // reciprocal scale for divide-by-word-size
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 22;

    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_CLR  = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first_bit;
        logic [16:0] run_length;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [15:0] last_set_index;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_MUL,
        S_DIV_BACK,
        S_DIV_FIX,
        S_RUN,
        S_SRCH,
        S_FIN
    } t_state;

endpackage

>>> rtl/bitmap_range_update_last_set_core.sv
// ----------------------------------------------------------------------------
// bitmap_range_update_last_set_core
// Allocation bitmap in one memory: set run, clear run, find highest set bit.
// ----------------------------------------------------------------------------
//  channel | direction | signals                              | word
//  in      | to core   | i_in_valid  o_in_ready  i_in        | t_in_word
//  out     | from core | o_out_valid i_out_ready o_out       | t_out_word
//  cfg     | to core   | i_cfg_valid o_cfg_ready i_cfg_data  | bitmap_bytes
//
//  Reset runs a clearing pass over all BITMAP_WORDS words; no input word is taken
//  until it ends, config writes are taken throughout.
//  Set/clear: after the divide steps (multiply, back-multiply, fix-up) the
//  run state reads one memory word and writes back the previous one each
//  cycle.
//  Find: the same divide steps, then words scanned from the top down, one read per cycle.
//  Flagged, zero-length and empty cases go from idle straight to the finish state.
//  A new input word is taken while a finished result waits on o_out.
// ----------------------------------------------------------------------------
module bitmap_range_update_last_set_core
    import bmru_pkg::*;
#(
    parameter int BITMAP_WORDS = DEF_BITMAP_WORDS,
    parameter int WORD_BITS    = DEF_WORD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_BYTES_W-1:0] i_cfg_data
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int OW = $clog2(WORD_BITS);
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int DW = 17;
    localparam int PW = DW + RECIP_W;
    localparam int CAP_BYTES = BITMAP_WORDS * WORD_BITS / 8;
    localparam logic [19:0] CAP_B = 20'(CAP_BYTES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / WORD_BITS);
    localparam logic [CW-1:0] WB_C = CW'(WORD_BITS);
    localparam logic [DW-1:0] WB_D = DW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONES = '1;

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    t_state               r_state, n_state;
    logic [CFG_BYTES_W-1:0] r_bytes;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic                 r_is_set, n_is_set;
    logic                 r_is_find, n_is_find;
    logic [DW-1:0]        r_div_a, n_div_a;
    logic [PW-1:0]        r_prod, n_prod;
    logic [DW-1:0]        r_q, n_q;
    logic [DW-1:0]        r_qw, n_qw;
    logic [AW-1:0]        r_addr, n_addr;
    logic [OW-1:0]        r_off, n_off;
    logic [16:0]          r_rem, n_rem;
    logic                 r_more, n_more;
    logic [DW-1:0]        r_base, n_base;
    logic [WORD_BITS-1:0] r_topmask, n_topmask;
    logic                 r_first, n_first;
    logic                 r_p_valid, n_p_valid;
    logic [AW-1:0]        r_p_addr, n_p_addr;
    logic [WORD_BITS-1:0] r_p_mask, n_p_mask;
    logic [DW-1:0]        r_p_base, n_p_base;
    logic                 r_p_last, n_p_last;
    logic [WORD_BITS-1:0] r_rdata;
    t_out_word            r_res, n_res;
    t_out_word            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_we, w_re;
    logic [AW-1:0]        w_wa, w_ra;
    logic [WORD_BITS-1:0] w_wd;

    logic [CFG_BYTES_W-1:0] w_bytes_eff;
    logic [DW-1:0]        w_size;
    logic [17:0]          w_end;
    logic [DW-1:0]        w_qest;
    logic [DW-1:0]        w_r;
    logic [DW-1:0]        w_qf, w_qwf, w_rf;
    logic [CW-1:0]        w_room, w_take, w_hi;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_v;
    logic [OW-1:0]        w_msb;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_bytes_eff = ({6'b0, r_bytes} > CAP_B) ? CAP_B[CFG_BYTES_W-1:0] : r_bytes;
    assign w_size      = {w_bytes_eff, 3'b000};
    assign w_end       = 18'(i_in.first_bit) + 18'(i_in.run_length);
    assign w_qest      = DW'(r_prod[PW-1:RECIP_SHIFT]);
    assign w_r         = r_div_a - r_qw;

    always_comb begin
        if (w_r >= WB_D) begin
            w_qf  = r_q + 1'b1;
            w_qwf = r_qw + WB_D;
            w_rf  = w_r - WB_D;
        end else begin
            w_qf  = r_q;
            w_qwf = r_qw;
            w_rf  = w_r;
        end
    end

    // run word mask
    assign w_room = WB_C - CW'(r_off);
    assign w_take = (17'(w_room) > r_rem) ? r_rem[CW-1:0] : w_room;
    assign w_hi   = CW'(r_off) + w_take;
    assign w_mask = (ONES >> (WB_C - w_hi)) & ~(ONES >> (WB_C - CW'(r_off)));

    // highest set bit of the checked word
    assign w_v = r_rdata & r_p_mask;
    always_comb begin
        w_msb = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w_v[i]) begin
                w_msb = OW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_is_set    = r_is_set;
        n_is_find   = r_is_find;
        n_div_a     = r_div_a;
        n_prod      = r_prod;
        n_q         = r_q;
        n_qw        = r_qw;
        n_addr      = r_addr;
        n_off       = r_off;
        n_rem       = r_rem;
        n_more      = r_more;
        n_base      = r_base;
        n_topmask   = r_topmask;
        n_first     = r_first;
        n_p_valid   = r_p_valid;
        n_p_addr    = r_p_addr;
        n_p_mask    = r_p_mask;
        n_p_base    = r_p_base;
        n_p_last    = r_p_last;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_wa        = r_p_addr;
        w_wd        = r_is_set ? (r_rdata | r_p_mask) : (r_rdata & ~r_p_mask);
        w_re        = 1'b0;
        w_ra        = r_addr;

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_wa       = r_clr_addr;
                w_wd       = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res     = '0;
                    n_is_set  = (i_in.kind == KIND_SET);
                    n_is_find = (i_in.kind == KIND_FIND);
                    n_rem     = i_in.run_length;
                    n_state   = S_FIN;
                    if (i_in.kind == KIND_SET || i_in.kind == KIND_CLR) begin
                        if (i_in.run_length != '0) begin
                            if (w_end > {1'b0, w_size}) begin
                                n_res.status = 1'b1;
                            end else begin
                                n_div_a = DW'(i_in.first_bit);
                                n_state = S_DIV_MUL;
                            end
                        end
                    end else if (i_in.kind == KIND_FIND) begin
                        if (w_size != '0) begin
                            n_div_a = w_size - 1'b1;
                            n_state = S_DIV_MUL;
                        end
                    end
                end
            end
            S_DIV_MUL: begin
                n_prod  = PW'(r_div_a) * PW'(RECIP);
                n_state = S_DIV_BACK;
            end
            S_DIV_BACK: begin
                n_q     = w_qest;
                n_qw    = DW'(w_qest * WB_D);
                n_state = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                n_addr    = w_qf[AW-1:0];
                n_more    = 1'b1;
                n_p_valid = 1'b0;
                if (r_is_find) begin
                    n_base    = w_qwf;
                    n_topmask = ONES >> (WB_C - (CW'(w_rf) + 1'b1));
                    n_first   = 1'b1;
                    n_state   = S_SRCH;
                end else begin
                    n_off   = w_rf[OW-1:0];
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_p_valid = r_more;
                if (r_more) begin
                    w_re     = 1'b1;
                    n_p_addr = r_addr;
                    n_p_mask = w_mask;
                    n_rem    = r_rem - 17'(w_take);
                    n_off    = '0;
                    n_addr   = r_addr + 1'b1;
                    n_more   = (r_rem != 17'(w_take));
                end
                if (r_p_valid) begin
                    w_we = 1'b1;
                end
                if (!r_more && !r_p_valid) begin
                    n_state = S_FIN;
                end
            end
            S_SRCH: begin
                n_p_valid = r_more;
                if (r_more) begin
                    w_re     = 1'b1;
                    n_p_addr = r_addr;
                    n_p_base = r_base;
                    n_p_last = (r_addr == '0);
                    n_p_mask = r_first ? r_topmask : ONES;
                    n_first  = 1'b0;
                    n_addr   = r_addr - 1'b1;
                    n_base   = r_base - WB_D;
                    n_more   = (r_addr != '0);
                end
                if (r_p_valid) begin
                    if (w_v != '0) begin
                        n_res.found          = 1'b1;
                        n_res.last_set_index = 16'(r_p_base + DW'(w_msb));
                        n_more               = 1'b0;
                        n_p_valid            = 1'b0;
                        n_state              = S_FIN;
                    end else if (r_p_last) begin
                        n_more    = 1'b0;
                        n_p_valid = 1'b0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bytes     <= RESET_BYTES;
            r_more      <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_more      <= n_more;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_bytes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_set  <= n_is_set;
        r_is_find <= n_is_find;
        r_div_a   <= n_div_a;
        r_prod    <= n_prod;
        r_q       <= n_q;
        r_qw      <= n_qw;
        r_addr    <= n_addr;
        r_off     <= n_off;
        r_rem     <= n_rem;
        r_base    <= n_base;
        r_topmask <= n_topmask;
        r_first   <= n_first;
        r_p_addr  <= n_p_addr;
        r_p_mask  <= n_p_mask;
        r_p_base  <= n_p_base;
        r_p_last  <= n_p_last;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // bitmap store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= mem[w_ra];
        end
    end

`ifndef SYNTHESIS
    a_no_rw_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_wa != w_ra))
        else $error("read and write-back hit the same bitmap word");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    a_flag_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status) |-> (!o_out.found && o_out.last_set_index == '0))
        else $error("flagged result carries search fields");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_we) |-> $past(w_re))
        else $error("write-back without a prior read");
`endif

endmodule

>>> tb/sv/bitmap_range_update_last_set_core_tb.sv
// ----------------------------------------------------------------------------
// bitmap_range_update_last_set_core_tb
// Self-checking bench for the allocation bitmap core. A shadow bitmap is
// updated at every accepted request word and the predicted response word is
// queued. Each response word is then compared field by field. Directed
// requests cover run edges, zero lengths, out-of-range runs and the size
// extremes. Random phases follow at several bitmap sizes, with bursty input
// and a stalling output.
// ----------------------------------------------------------------------------
module bitmap_range_update_last_set_core_tb;
    import bmru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAP_WORDS = DEF_BITMAP_WORDS;
    localparam int          WORD_W    = DEF_WORD_BITS;
    localparam int unsigned CAP_BYTES = MAP_WORDS * WORD_W / 8;
    localparam logic [1:0]  KIND_NONE = 2'd3;

    logic                   i_clk       = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    t_in_word               in_word     = '0;
    logic                   out_ready   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_BYTES_W-1:0] cfg_data    = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_out_word              o_out;
    logic                   o_cfg_ready;

    logic [WORD_W-1:0]      shadow_map [MAP_WORDS];
    int unsigned            size_bytes_q;
    t_out_word              awaited_words [$];
    t_in_word               pending_reqs [$];
    int unsigned            n_pushed    = 0;
    int unsigned            n_accepted  = 0;
    int unsigned            err_count   = 0;

    bit                     sender_gaps = 1'b0;
    int unsigned            burst_left  = 0;
    int unsigned            gap_left    = 0;
    logic [12:0]            stall_pat   = '1;
    int unsigned            pat_pos     = 0;

    bitmap_range_update_last_set_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("bitmap_range_update_last_set_core_tb: FAIL");
        $finish;
    end

    // ---------------- shadow bitmap ----------------
    function automatic logic [WORD_W-1:0] low_mask(input int unsigned n);
        if (n >= WORD_W) return '1;
        return ({{(WORD_W-1){1'b0}}, 1'b1} << n) - 1'b1;
    endfunction

    function automatic void fill_run(input int unsigned first, input int unsigned last,
                                     input bit do_set);
        int unsigned pos, wi, b, take;
        logic [WORD_W-1:0] m;
        pos = first;
        while (pos < last) begin
            wi   = pos / WORD_W;
            b    = pos % WORD_W;
            take = WORD_W - b;
            if (take > last - pos) take = last - pos;
            m = low_mask(b + take) & ~low_mask(b);
            if (do_set) shadow_map[wi] |= m;
            else        shadow_map[wi] &= ~m;
            pos += take;
        end
    endfunction

    function automatic t_out_word predict_req(input t_in_word w);
        t_out_word r;
        int unsigned span, last, top;
        logic [WORD_W-1:0] v;
        r    = '0;
        span = (size_bytes_q > CAP_BYTES ? CAP_BYTES : size_bytes_q) * 8;
        case (w.kind)
            KIND_SET, KIND_CLR: begin
                if (w.run_length != 0) begin
                    last = w.first_bit + w.run_length;
                    if (last > span) r.status = 1'b1;
                    else fill_run(w.first_bit, last, w.kind == KIND_SET);
                end
            end
            KIND_FIND: begin
                if (span != 0) begin
                    top = (span - 1) / WORD_W;
                    for (int wi = top; wi >= 0 && !r.found; wi--) begin
                        v = shadow_map[wi];
                        if (wi == top) v &= low_mask(span - wi * WORD_W);
                        for (int b = WORD_W - 1; b >= 0 && !r.found; b--) begin
                            if (v[b]) begin
                                r.found          = 1'b1;
                                r.last_set_index = 16'(wi * WORD_W + b);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        err_count++;
        if (err_count <= 100)
            $display("[%0t] mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // ---------------- request driver ----------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                in_valid <= 1'b1;
                in_word  <= pending_reqs.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= sender_gaps ? $urandom_range(1, 7) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- response stall pattern ----------------
    always @(posedge i_clk) begin
        pat_pos   <= (pat_pos == 12) ? 0 : pat_pos + 1;
        out_ready <= stall_pat[pat_pos];
    end

    // ---------------- predictor and checker ----------------
    always @(posedge i_clk) begin : monitor
        t_out_word exp_w;
        if (!rst_n) begin
            foreach (shadow_map[i]) shadow_map[i] = '0;
            size_bytes_q = RESET_BYTES;
        end else begin
            if (cfg_valid && o_cfg_ready) size_bytes_q = cfg_data;
            if (o_out_valid && out_ready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("unexpected word", 0, o_out);
                end else begin
                    exp_w = awaited_words.pop_front();
                    if (o_out.status !== exp_w.status)
                        report_mismatch("status", exp_w.status, o_out.status);
                    if (o_out.found !== exp_w.found)
                        report_mismatch("found", exp_w.found, o_out.found);
                    if (o_out.last_set_index !== exp_w.last_set_index)
                        report_mismatch("last_set_index", exp_w.last_set_index,
                                        o_out.last_set_index);
                end
            end
            if (in_valid && o_in_ready) begin
                awaited_words.push_back(predict_req(in_word));
                n_accepted++;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_word(input logic [1:0] kind, input int unsigned start,
                             input int unsigned len);
        t_in_word w;
        w.kind       = kind;
        w.first_bit  = start[15:0];
        w.run_length = len[16:0];
        while (pending_reqs.size() >= 2) @(posedge i_clk);
        pending_reqs.push_back(w);
        n_pushed++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || awaited_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_size(input int unsigned bytes);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= bytes[CFG_BYTES_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input bit gaps, input bit stalls);
        sender_gaps = gaps;
        stall_pat  <= stalls ? (13'($urandom_range(0, 8191)) | 13'h1) : '1;
    endtask

    // span: bits in use for the current size
    task automatic send_random_req(input int unsigned span);
        logic [1:0] kind;
        int unsigned r, s, len, lmax;
        r = $urandom_range(0, 99);
        if (r < 40)      kind = KIND_SET;
        else if (r < 70) kind = KIND_CLR;
        else if (r < 95) kind = KIND_FIND;
        else             kind = KIND_NONE;
        r = (span == 0) ? $urandom_range(80, 99) : $urandom_range(0, 99);
        if (r < 80) begin
            s    = $urandom_range(0, span - 1);
            lmax = span - s;
            if ($urandom_range(0, 9) != 0 && lmax > 192) lmax = 192;
            len  = $urandom_range(1, lmax);
        end else if (r < 88) begin
            s   = (span == 0) ? $urandom_range(0, 255) : $urandom_range(0, span - 1);
            len = (span > s ? span - s : 0) + $urandom_range(1, 64);
        end else if (r < 93) begin
            s   = $urandom_range(0, 65535);
            len = 0;
        end else begin
            s   = $urandom_range(0, 65535);
            len = $urandom_range(0, 131071);
        end
        send_word(kind, s, len);
    endtask

    // ---------------- tests ----------------
    task automatic test_empty_after_reset();
        set_idling(1'b0, 1'b0);
        send_word(KIND_FIND, 0, 0);
        send_word(KIND_NONE, 65535, 131071);
        send_word(KIND_SET, 0, 1);
        send_word(KIND_FIND, 65535, 65536);
        send_word(KIND_SET, 65535, 1);
        send_word(KIND_FIND, 0, 0);
        send_word(KIND_SET, 65535, 2);
        send_word(KIND_CLR, 65535, 0);
        send_word(KIND_SET, 0, 65536);
        send_word(KIND_CLR, 1, 65536);
        send_word(KIND_CLR, 0, 65536);
        send_word(KIND_FIND, 0, 0);
        send_word(KIND_SET, 3, 70);
        send_word(KIND_CLR, 10, 5);
        send_word(KIND_FIND, 0, 0);
    endtask

    task automatic test_size_extremes();
        write_size(0);
        send_word(KIND_SET, 0, 1);
        send_word(KIND_FIND, 0, 0);
        send_word(KIND_CLR, 0, 0);
        write_size(1);
        send_word(KIND_SET, 7, 1);
        send_word(KIND_SET, 8, 1);
        send_word(KIND_FIND, 0, 0);
        write_size(3);
        send_word(KIND_SET, 20, 4);
        send_word(KIND_FIND, 0, 0);
        write_size(16383);
        send_word(KIND_SET, 65535, 1);
        send_word(KIND_FIND, 0, 0);
        send_word(KIND_SET, 65000, 600);
    endtask

    task automatic test_random_sizes();
        int unsigned sizes[11];
        int unsigned span;
        sizes = '{8192, 1, 16383, 0, 3, 0, 0, 0, 0, 8192, 0};
        sizes[5]  = $urandom_range(1, 64);
        sizes[6]  = $urandom_range(1, 64);
        sizes[7]  = $urandom_range(64, 512);
        sizes[8]  = $urandom_range(64, 512);
        sizes[10] = $urandom_range(8193, 16383);
        for (int p = 0; p < 11; p++) begin
            write_size(sizes[p]);
            set_idling(p != 0 && $urandom_range(0, 3) != 0,
                       p != 0 && $urandom_range(0, 3) != 0);
            span = (sizes[p] > CAP_BYTES ? CAP_BYTES : sizes[p]) * 8;
            repeat (70) send_random_req(span);
        end
    endtask

    task automatic test_drain_pause();
        int unsigned bytes;
        bytes = $urandom_range(64, 256);
        write_size(bytes);
        set_idling(1'b1, 1'b1);
        repeat (30) send_random_req(bytes * 8);
        wait_drained();
        repeat ($urandom_range(5, 40)) @(posedge i_clk);
        repeat (30) send_random_req(bytes * 8);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        test_empty_after_reset();
        test_size_extremes();
        test_random_sizes();
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("bitmap_range_update_last_set_core_tb: PASS");
        end else begin
            $display("bitmap_range_update_last_set_core_tb: FAIL");
        end
        $finish;
    end

endmodule
